// File: design/erp_pkg.sv
// Shared widths, reset values, codes and types of the error-to-speed ramp planner.
package erp_pkg;

  localparam int SPD_W  = 24;
  localparam int CE_W   = 15;
  localparam int ERR_W  = 16;
  localparam int ELAP_W = 16;
  localparam int MAG_W  = 17;
  localparam int PROD_W = 40;
  localparam int REM_W  = 15;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 31;

  localparam logic [SPD_W-1:0] STRAIGHT_RST = 24'd1000000;
  localparam logic [SPD_W-1:0] MIN_RST      = 24'd300000;
  localparam logic [CE_W-1:0]  CURVE_RST    = 15'd800;
  localparam logic [SPD_W-1:0] ACCEL_RST    = 24'd2000000;
  localparam logic [SPD_W-1:0] DECEL_RST    = 24'd2000000;

  localparam logic [CE_W-1:0]  MS_PER_S   = 15'd1000;
  localparam logic [CNT_W-1:0] MAP_STEPS  = 5'd12;
  localparam logic [CNT_W-1:0] RATE_STEPS = 5'd20;

  localparam logic [IDX_W-1:0] REG_STRAIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURVE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ACCEL    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DECEL    = 3'd4;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic [SPD_W-1:0] straight;
    logic [SPD_W-1:0] min_spd;
    logic [CE_W-1:0]  curve;
    logic [SPD_W-1:0] accel;
    logic [SPD_W-1:0] decel;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic skip;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: design/erp_cfg.sv
// Configuration register file of the ramp planner.
module erp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [erp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [erp_pkg::SPD_W-1:0]   cfg_wdata,
  output erp_pkg::cfg_t               cfg
);

  erp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.straight <= erp_pkg::STRAIGHT_RST;
      cfg_r.min_spd  <= erp_pkg::MIN_RST;
      cfg_r.curve    <= erp_pkg::CURVE_RST;
      cfg_r.accel    <= erp_pkg::ACCEL_RST;
      cfg_r.decel    <= erp_pkg::DECEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        erp_pkg::REG_STRAIGHT: cfg_r.straight <= cfg_wdata;
        erp_pkg::REG_MIN:      cfg_r.min_spd  <= cfg_wdata;
        erp_pkg::REG_CURVE:    cfg_r.curve    <= cfg_wdata[erp_pkg::CE_W-1:0];
        erp_pkg::REG_ACCEL:    cfg_r.accel    <= cfg_wdata;
        erp_pkg::REG_DECEL:    cfg_r.decel    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/erp_mul.sv
// Shared registered 24 x 16 multiplier of the ramp planner.
module erp_mul (
  input  logic                         clk,
  input  logic [erp_pkg::SPD_W-1:0]    a,
  input  logic [erp_pkg::ELAP_W-1:0]   b,
  output logic [erp_pkg::PROD_W-1:0]   p
);

  logic [erp_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {16'b0, a} * {24'b0, b};
  end

  assign p = p_r;

endmodule

// File: design/erp_div.sv
// Shared iterative divider of the ramp planner, two quotient bits per cycle.
module erp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erp_pkg::div_req_t             req,
  input  logic [erp_pkg::PROD_W-1:0]    dividend,
  input  logic [erp_pkg::CE_W-1:0]      divisor,
  output erp_pkg::div_sts_t             sts,
  output logic [erp_pkg::PROD_W-1:0]    quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [erp_pkg::CNT_W-1:0]     cnt_r;
  logic [erp_pkg::REM_W-1:0]     rem_r;
  logic [erp_pkg::PROD_W-1:0]    sh_r;
  logic [erp_pkg::PROD_W-1:0]    quo_r;
  logic [erp_pkg::CE_W-1:0]      dsr_r;

  logic [erp_pkg::REM_W:0]       r1;
  logic [erp_pkg::REM_W:0]       r2;
  logic                          ge1;
  logic                          ge2;
  logic [erp_pkg::REM_W-1:0]     rm1;
  logic [erp_pkg::REM_W-1:0]     rm2;

  always_comb begin
    r1  = {rem_r, sh_r[erp_pkg::PROD_W-1]};
    ge1 = r1 >= {1'b0, dsr_r};
    rm1 = ge1 ? erp_pkg::REM_W'(r1 - {1'b0, dsr_r}) : r1[erp_pkg::REM_W-1:0];
    r2  = {rm1, sh_r[erp_pkg::PROD_W-2]};
    ge2 = r2 >= {1'b0, dsr_r};
    rm2 = ge2 ? erp_pkg::REM_W'(r2 - {1'b0, dsr_r}) : r2[erp_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.skip ? erp_pkg::MAP_STEPS : erp_pkg::RATE_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr_r <= divisor;
      quo_r <= '0;
      if (req.skip) begin
        rem_r <= dividend[38:24];
        sh_r  <= {dividend[23:0], 16'b0};
      end else begin
        rem_r <= '0;
        sh_r  <= dividend;
      end
    end else if (busy_r) begin
      rem_r <= rm2;
      sh_r  <= {sh_r[erp_pkg::PROD_W-3:0], 2'b0};
      quo_r <= {quo_r[erp_pkg::PROD_W-3:0], ge1, ge2};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// File: design/error_to_speed_ramp_planner.sv
// Top level of the error-to-speed ramp planner: sequencer, speed state and result register.
//
// Input channel (in_valid/in_ready): one word per item. An update word carries a
// signed tracking error and the elapsed milliseconds; a restart word sets the speed
// to the minimum speed. Result channel (out_valid/out_ready): one word per item with
// the new speed, the clamped target and an at-target flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; the speed does not
// move on a write. Write only while no item is in flight.
// Sequencing: a restart word goes from idle straight to the result state. An update
// word runs the map and rate steps, with a map division only when the error falls
// on the sloped part of the map. The shared divider does the map division by the
// curve error and the step division by 1000, two quotient bits a cycle; one shared
// multiplier feeds it. in_ready is high only while the sequencer is idle, so one
// item is in flight at a time and the next word can be accepted as soon as a result
// is registered; a waiting result does not block that.
// Stall: a result waits in the output register until out_ready; the sequencer holds
// in its final state only if the register is still full then.
// Reset: rst_n, synchronous, active low; it restores the register reset values, sets
// the speed to the minimum speed reset value and empties the output register.
module error_to_speed_ramp_planner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic signed [erp_pkg::ERR_W-1:0]    in_track_error,
  input  logic [erp_pkg::ELAP_W-1:0]          in_elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [erp_pkg::SPD_W-1:0]           out_speed,
  output logic [erp_pkg::SPD_W-1:0]           out_target_speed,
  output logic                                out_at_target,
  input  logic                                cfg_we,
  input  logic [erp_pkg::IDX_W-1:0]           cfg_index,
  input  logic [erp_pkg::SPD_W-1:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_MMUL, S_MDIV, S_RATE, S_RMUL, S_RDIV, S_OUT
  } state_t;

  erp_pkg::cfg_t                   cfg;
  erp_pkg::div_req_t               div_req;
  erp_pkg::div_sts_t               div_sts;
  logic [erp_pkg::PROD_W-1:0]      div_quo;
  logic [erp_pkg::CE_W-1:0]        div_dsr;
  logic [erp_pkg::PROD_W-1:0]      mul_p;
  logic [erp_pkg::SPD_W-1:0]       mul_a;
  logic [erp_pkg::ELAP_W-1:0]      mul_b;

  state_t                          state_r, state_nxt;
  logic [erp_pkg::SPD_W-1:0]       cur_r, cur_nxt;
  logic [erp_pkg::SPD_W-1:0]       tgt_r, tgt_nxt;
  logic [erp_pkg::MAG_W-1:0]       mag_r, mag_nxt;
  logic [erp_pkg::ELAP_W-1:0]      elap_r, elap_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [erp_pkg::SPD_W-1:0]       out_speed_r, out_speed_nxt;
  logic [erp_pkg::SPD_W-1:0]       out_tgt_r, out_tgt_nxt;
  logic                            out_at_r, out_at_nxt;

  logic                            up;
  logic [erp_pkg::SPD_W-1:0]       rate_sel;
  logic [erp_pkg::SPD_W-1:0]       adiff;
  logic [erp_pkg::CAP_W-1:0]       cap;
  logic [erp_pkg::MAG_W-1:0]       in_mag;

  erp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  erp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  erp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (mul_p),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  always_comb begin
    in_mag   = in_track_error[erp_pkg::ERR_W-1] ?
               erp_pkg::MAG_W'({1'b0, ~in_track_error}) + 17'd1 :
               {1'b0, in_track_error};
    up       = tgt_r > cur_r;
    rate_sel = up ? cfg.accel : cfg.decel;
    adiff    = up ? tgt_r - cur_r : cur_r - tgt_r;
    cap      = div_quo[erp_pkg::CAP_W-1:0];

    state_nxt     = state_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    mag_nxt       = mag_r;
    elap_nxt      = elap_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_speed_nxt = out_speed_r;
    out_tgt_nxt   = out_tgt_r;
    out_at_nxt    = out_at_r;
    div_req       = '0;
    div_dsr       = erp_pkg::MS_PER_S;
    mul_a         = rate_sel;
    mul_b         = elap_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == erp_pkg::OP_RESTART) begin
            cur_nxt   = cfg.min_spd;
            tgt_nxt   = cfg.min_spd;
            state_nxt = S_OUT;
          end else begin
            mag_nxt   = in_mag;
            elap_nxt  = in_elapsed_ms;
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        mul_a = cfg.straight - cfg.min_spd;
        mul_b = {1'b0, mag_r[erp_pkg::CE_W-1:0]};
        if (cfg.curve == '0) begin
          tgt_nxt   = (cfg.straight < cfg.min_spd) ? cfg.min_spd : cfg.straight;
          state_nxt = S_RATE;
        end else if (mag_r >= {2'b0, cfg.curve}) begin
          tgt_nxt   = (cfg.min_spd > cfg.straight) ? cfg.straight : cfg.min_spd;
          state_nxt = S_RATE;
        end else if (cfg.min_spd >= cfg.straight) begin
          tgt_nxt   = cfg.min_spd;
          state_nxt = S_RATE;
        end else begin
          state_nxt = S_MMUL;
        end
      end
      S_MMUL: begin
        div_req.start = 1'b1;
        div_req.skip  = 1'b1;
        div_dsr       = cfg.curve;
        state_nxt     = S_MDIV;
      end
      S_MDIV: begin
        if (div_sts.done) begin
          tgt_nxt   = cfg.straight - div_quo[erp_pkg::SPD_W-1:0];
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        div_req.start = 1'b1;
        div_req.skip  = 1'b0;
        state_nxt     = S_RDIV;
      end
      S_RDIV: begin
        if (div_sts.done) begin
          if ({7'b0, adiff} <= cap) begin
            cur_nxt = tgt_r;
          end else if (up) begin
            cur_nxt = cur_r + cap[erp_pkg::SPD_W-1:0];
          end else begin
            cur_nxt = cur_r - cap[erp_pkg::SPD_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = cur_r;
          out_tgt_nxt   = tgt_r;
          out_at_nxt    = cur_r == tgt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= erp_pkg::MIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r       <= tgt_nxt;
    mag_r       <= mag_nxt;
    elap_r      <= elap_nxt;
    out_speed_r <= out_speed_nxt;
    out_tgt_r   <= out_tgt_nxt;
    out_at_r    <= out_at_nxt;
  end

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_speed        = out_speed_r;
  assign out_target_speed = out_tgt_r;
  assign out_at_target    = out_at_r;

`ifndef NO_ASSERTIONS
  a_restart_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == erp_pkg::OP_RESTART) |=>
      (cur_r == $past(cfg.min_spd)))
    else $error("restart did not load the minimum speed");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_MDIV || state_r == S_RDIV))
    else $error("divider finished while the sequencer was not waiting");

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_sts.busy)
    else $error("divider busy while the sequencer is idle");

  a_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_at_target == (out_speed == out_target_speed)))
    else $error("at_target flag disagrees with speed and target");
`endif

endmodule
